>>> rtl/hns_pkg.sv
`timescale 1ns / 1ps
package hns_pkg;

  // Fixed-point output format
  localparam int FRAC_W = 14;
  localparam int QUO_W  = 16;
  localparam logic [QUO_W-1:0] Q_ONE = 16'd16384;

  // Fixed field widths
  localparam int ROW_W  = 10;
  localparam int COL_W  = 10;
  localparam int NS_W   = 3;
  localparam int NY_W   = 18;
  localparam int RLEN_W = 11;
  localparam int WS_W   = 16;

  // Configuration register indexes and reset values
  localparam logic REG_ROW_LENGTH  = 1'b0;
  localparam logic REG_WIDTH_SCALE = 1'b1;
  localparam logic [RLEN_W-1:0] ROW_LENGTH_RST  = 11'd1024;
  localparam logic [WS_W-1:0]   WIDTH_SCALE_RST = 16'd256;

  // Saturate a quotient to one and apply the sign of the component
  function automatic logic [QUO_W-1:0] sat_sign(input logic [QUO_W-1:0] q,
                                                input logic neg);
    logic [QUO_W-1:0] s;
    s = (q > Q_ONE) ? Q_ONE : q;
    return neg ? (~s + 1'b1) : s;
  endfunction

endpackage

>>> rtl/hns_fifo.sv
`timescale 1ns / 1ps
module hns_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  // Store an incoming word
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("push while queue full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop while queue empty");

endmodule

>>> rtl/hns_front.sv
`timescale 1ns / 1ps
module hns_front #(
  parameter int MAX_ROW_LENGTH = 1024,
  parameter int HEIGHT_BITS    = 16,
  parameter int AW             = 10,
  parameter int EW             = 18,
  parameter int QW             = 51
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic signed [HEIGHT_BITS-1:0] height,
  input  logic [hns_pkg::RLEN_W-1:0]    row_length,
  output logic                          q_push,
  output logic [QW-1:0]                 q_data,
  input  logic                          q_full
);

  localparam int LW = $clog2(MAX_ROW_LENGTH + 1);
  localparam int CW = (LW > hns_pkg::RLEN_W) ? LW : hns_pkg::RLEN_W;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_RD0  = 4'b0010,
    F_RD1  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t state;

  logic signed [HEIGHT_BITS-1:0] upper_mem [MAX_ROW_LENGTH];
  logic signed [HEIGHT_BITS-1:0] older_mem [MAX_ROW_LENGTH];
  logic signed [HEIGHT_BITS-1:0] up_rdata;
  logic signed [HEIGHT_BITS-1:0] old_rdata;
  logic [AW-1:0] up_raddr;
  logic [AW-1:0] old_raddr;
  logic          rd_en;

  logic [hns_pkg::ROW_W-1:0] row_pos;
  logic [AW-1:0]             col_pos;

  // Latched item
  logic                          drain;
  logic signed [HEIGHT_BITS-1:0] h;
  logic [AW-1:0]                 c;
  logic [hns_pkg::ROW_W-1:0]     r;
  logic                          has_right;
  logic                          last_col;
  logic signed [HEIGHT_BITS-1:0] p;
  logic signed [HEIGHT_BITS-1:0] o;

  // Clamped row length and column
  logic [CW-1:0] rl_ext;
  logic [LW-1:0] clen;
  logic [AW-1:0] c_use;
  logic [LW-1:0] c_next;

  assign rl_ext = CW'(row_length);
  always_comb begin
    if (rl_ext < CW'(2)) begin
      clen = LW'(2);
    end else if (rl_ext > CW'(MAX_ROW_LENGTH)) begin
      clen = LW'(MAX_ROW_LENGTH);
    end else begin
      clen = LW'(rl_ext);
    end
    c_use  = (LW'(col_pos) >= clen) ? AW'(clen - LW'(1)) : col_pos;
    c_next = LW'(c_use) + LW'(1);
  end

  logic accept;
  logic emit;
  logic go;

  assign in_ready = (state == F_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit     = (r != '0);
  assign go       = (state == F_PUSH) && (!emit || !q_full);
  assign q_push   = (state == F_PUSH) && emit && !q_full;

  // Read addresses: vertex column first, then the right and left neighbors
  always_comb begin
    rd_en     = 1'b0;
    up_raddr  = c;
    old_raddr = c;
    case (state)
      F_RD0: begin
        rd_en = 1'b1;
      end
      F_RD1: begin
        rd_en     = 1'b1;
        up_raddr  = c + AW'(1);
        old_raddr = c - AW'(1);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Line buffers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_rdata  <= upper_mem[up_raddr];
      old_rdata <= older_mem[old_raddr];
    end
    if (go) begin
      older_mem[c] <= p;
      if (!drain) begin
        upper_mem[c] <= h;
      end
    end
  end

  // Neighbor sums
  logic signed [EW-1:0]       nx;
  logic signed [EW-1:0]       nz;
  logic [hns_pkg::NS_W-1:0]   ns;

  always_comb begin
    nx = '0;
    nz = '0;
    ns = '0;
    if (!drain) begin
      nx = nx + EW'(p) - EW'(h);
      ns = ns + 1'b1;
    end
    if (r > hns_pkg::ROW_W'(1)) begin
      nx = nx + EW'(o) - EW'(p);
      ns = ns + 1'b1;
    end
    if (has_right) begin
      nz = nz + EW'(p) - EW'(up_rdata);
      ns = ns + 1'b1;
    end
    if (c != '0) begin
      nz = nz + EW'(old_rdata) - EW'(p);
      ns = ns + 1'b1;
    end
  end

  assign q_data = {nx, nz, ns, hns_pkg::ROW_W'(r - 1'b1), c};

  // Sequence one item
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      row_pos <= '0;
      col_pos <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept && !(cmd && row_pos == '0)) begin
            state <= F_RD0;
          end
        end
        F_RD0: begin
          state <= F_RD1;
        end
        F_RD1: begin
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (go) begin
            state <= F_IDLE;
            if (last_col) begin
              col_pos <= '0;
              row_pos <= drain ? '0 : r + 1'b1;
            end else begin
              col_pos <= c + AW'(1);
            end
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  // Hold the item and the vertex heights
  always_ff @(posedge clk) begin
    if (accept) begin
      drain     <= cmd;
      h         <= height;
      c         <= c_use;
      r         <= row_pos;
      has_right <= (c_next < clen);
      last_col  <= (c_next >= clen);
    end
    if (state == F_RD1) begin
      p <= up_rdata;
      o <= old_rdata;
    end
  end

endmodule

>>> rtl/hns_back.sv
`timescale 1ns / 1ps
module hns_back #(
  parameter int AW = 10,
  parameter int EW = 18,
  parameter int QW = 51
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [QW-1:0]            q_data,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  logic [hns_pkg::WS_W-1:0] width_scale,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [15:0]       normal_x,
  output logic [14:0]              normal_y,
  output logic signed [15:0]       normal_z,
  output logic [hns_pkg::ROW_W-1:0] vertex_row,
  output logic [hns_pkg::COL_W-1:0] vertex_col
);

  localparam int MW  = (EW > hns_pkg::NY_W) ? EW : hns_pkg::NY_W;
  localparam int SW  = 2 * MW + 2;
  localparam int NW  = MW + 1;
  localparam int RW  = NW + 2;
  localparam int DW  = NW + hns_pkg::FRAC_W + 1;
  localparam int QB  = hns_pkg::QUO_W;
  localparam int ITW = $clog2(NW + 1);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_SQ   = 6'b000010,
    B_SQRT = 6'b000100,
    B_DSET = 6'b001000,
    B_DIV  = 6'b010000,
    B_DONE = 6'b100000
  } bstate_t;

  bstate_t state;

  // Unpack queue word
  logic signed [EW-1:0]       in_nx;
  logic signed [EW-1:0]       in_nz;
  logic [hns_pkg::NS_W-1:0]   in_ns;
  logic [hns_pkg::ROW_W-1:0]  in_row;
  logic [AW-1:0]              in_col;
  assign {in_nx, in_nz, in_ns, in_row, in_col} = q_data;

  logic [MW-1:0] mag_x, mag_y, mag_z;
  logic          neg_x, neg_z;
  logic [hns_pkg::ROW_W-1:0] e_row;
  logic [AW-1:0]             e_col;

  logic [1:0]      sq_cnt;
  logic [MW-1:0]   sq_sel;
  logic [2*MW-1:0] prod;
  logic [SW-1:0]   acc;

  logic [RW-1:0]   rem_s;
  logic [NW-1:0]   root;
  logic [ITW-1:0]  iter;
  logic [RW+1:0]   rem_t;
  logic [RW+1:0]   trial;

  logic [1:0]      comp;
  logic [MW-1:0]   d_mag;
  logic            d_neg;
  logic [DW-1:0]   dvd;
  logic [NW-1:0]   d_rem;
  logic [QB-1:0]   d_lo;
  logic [QB-1:0]   d_q;
  logic [4:0]      bitc;
  logic [NW:0]     rs;
  logic            qbit;
  logic [QB-1:0]   q_fin;
  logic [QB-1:0]   q_out;

  logic [QB-1:0] res_x, res_y, res_z;

  assign q_pop = (state == B_IDLE) && !q_empty;

  // Operand select for the shared squarer
  always_comb begin
    case (sq_cnt)
      2'd0:    sq_sel = mag_x;
      2'd1:    sq_sel = mag_y;
      default: sq_sel = mag_z;
    endcase
  end

  // One root digit per step
  assign rem_t = {rem_s, acc[SW-1:SW-2]};
  assign trial = (RW + 2)'({root, 2'b01});

  // Component select and dividend for the divider
  always_comb begin
    case (comp)
      2'd0: begin
        d_mag = mag_x;
        d_neg = neg_x;
      end
      2'd1: begin
        d_mag = mag_y;
        d_neg = 1'b0;
      end
      default: begin
        d_mag = mag_z;
        d_neg = neg_z;
      end
    endcase
    dvd = (DW'(d_mag) << hns_pkg::FRAC_W) + DW'(root >> 1);
  end

  // One quotient bit per step
  assign rs    = {d_rem, d_lo[QB-1]};
  assign qbit  = (rs >= (NW + 1)'(root));
  assign q_fin = {d_q[QB-2:0], qbit};
  assign q_out = hns_pkg::sat_sign(q_fin, d_neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            state <= B_SQ;
          end
        end
        B_SQ: begin
          if (sq_cnt == 2'd3) begin
            state <= B_SQRT;
          end
        end
        B_SQRT: begin
          if (iter == ITW'(NW - 1)) begin
            state <= B_DSET;
          end
        end
        B_DSET: begin
          state <= (root == '0) ? B_DONE : B_DIV;
        end
        B_DIV: begin
          if (bitc == 5'(QB - 1)) begin
            state <= (comp == 2'd2) ? B_DONE : B_DSET;
          end
        end
        B_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        mag_x  <= MW'(in_nx < 0 ? -in_nx : in_nx);
        mag_z  <= MW'(in_nz < 0 ? -in_nz : in_nz);
        neg_x  <= (in_nx < 0);
        neg_z  <= (in_nz < 0);
        mag_y  <= MW'(width_scale) * MW'(in_ns);
        e_row  <= in_row;
        e_col  <= in_col;
        sq_cnt <= 2'd0;
        acc    <= '0;
      end
      B_SQ: begin
        prod   <= sq_sel * sq_sel;
        sq_cnt <= sq_cnt + 2'd1;
        if (sq_cnt != 2'd0) begin
          acc <= acc + SW'(prod);
        end
        rem_s <= '0;
        root  <= '0;
        iter  <= '0;
        comp  <= 2'd0;
      end
      B_SQRT: begin
        if (rem_t >= trial) begin
          rem_s <= RW'(rem_t - trial);
          root  <= {root[NW-2:0], 1'b1};
        end else begin
          rem_s <= RW'(rem_t);
          root  <= {root[NW-2:0], 1'b0};
        end
        acc  <= acc << 2;
        iter <= iter + ITW'(1);
      end
      B_DSET: begin
        d_rem <= NW'(dvd[DW-1:QB]);
        d_lo  <= dvd[QB-1:0];
        d_q   <= '0;
        bitc  <= '0;
        if (root == '0) begin
          res_x <= '0;
          res_y <= hns_pkg::Q_ONE;
          res_z <= '0;
        end
      end
      B_DIV: begin
        d_rem <= qbit ? NW'(rs - (NW + 1)'(root)) : NW'(rs);
        d_lo  <= d_lo << 1;
        d_q   <= q_fin;
        bitc  <= bitc + 5'd1;
        if (bitc == 5'(QB - 1)) begin
          comp <= comp + 2'd1;
          case (comp)
            2'd0:    res_x <= q_out;
            2'd1:    res_y <= q_out;
            default: res_z <= q_out;
          endcase
        end
      end
      B_DONE: begin
        if (!out_valid || out_ready) begin
          normal_x   <= res_x;
          normal_y   <= res_y[14:0];
          normal_z   <= res_z;
          vertex_row <= e_row;
          vertex_col <= hns_pkg::COL_W'(e_col);
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  a_y_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (normal_y <= 15'd16384)) else $error("normal_y out of range");
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (normal_x >= -16'sd16384 && normal_x <= 16'sd16384))
    else $error("normal_x out of range");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == B_SQ)) else $error("pop did not start a normal");

endmodule

>>> rtl/heightmap_normal_stencil.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Words
// in        in_valid / in_ready        cmd, height
// out       out_valid / out_ready      normal_x, normal_y, normal_z, vertex_row, vertex_col
// cfg       psel / penable / pready    paddr, pwdata, prdata (row_length at 0, width_scale at 4)
//
// The front takes a new word only after the last one has gone through the line-buffer read
// sequence (vertex column, then its right and left neighbors) and its push, which a full queue stalls.
// The back works on one normal at a time, through the bit-serial square root of the
// 2*MW+2 bit sum of squares and the shared restoring divider (MW = max(HEIGHT_BITS+2, 18)).
// A two-word queue lets the front run ahead while the back or the output stalls.
// Synchronous reset clears position counters and control; line buffers are not cleared.
module heightmap_normal_stencil #(
  parameter int MAX_ROW_LENGTH = 1024,
  parameter int HEIGHT_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic signed [HEIGHT_BITS-1:0] height,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            normal_x,
  output logic [14:0]                   normal_y,
  output logic signed [15:0]            normal_z,
  output logic [9:0]                    vertex_row,
  output logic [9:0]                    vertex_col
);

  localparam int AW = $clog2(MAX_ROW_LENGTH);
  localparam int EW = HEIGHT_BITS + 2;
  localparam int QW = 2 * EW + hns_pkg::NS_W + hns_pkg::ROW_W + AW;

  logic [hns_pkg::RLEN_W-1:0] row_length;
  logic [hns_pkg::WS_W-1:0]   width_scale;

  // Register writes
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length  <= hns_pkg::ROW_LENGTH_RST;
      width_scale <= hns_pkg::WIDTH_SCALE_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        hns_pkg::REG_ROW_LENGTH:  row_length  <= pwdata[hns_pkg::RLEN_W-1:0];
        hns_pkg::REG_WIDTH_SCALE: width_scale <= pwdata[hns_pkg::WS_W-1:0];
        default:                  row_length  <= row_length;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[2])
      hns_pkg::REG_ROW_LENGTH:  prdata = 32'(row_length);
      hns_pkg::REG_WIDTH_SCALE: prdata = 32'(width_scale);
      default:                  prdata = '0;
    endcase
  end

  logic          q_push;
  logic [QW-1:0] q_wdata;
  logic          q_full;
  logic          q_pop;
  logic [QW-1:0] q_rdata;
  logic          q_empty;

  hns_front #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
    .HEIGHT_BITS   (HEIGHT_BITS),
    .AW            (AW),
    .EW            (EW),
    .QW            (QW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .height    (height),
    .row_length(row_length),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  hns_fifo #(
    .W(QW)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty)
  );

  hns_back #(
    .AW(AW),
    .EW(EW),
    .QW(QW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (q_rdata),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .width_scale(width_scale),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .vertex_row (vertex_row),
    .vertex_col (vertex_col)
  );

endmodule

>>> sim/tb_heightmap_normal_stencil.sv
`timescale 1ns / 1ps
module tb_heightmap_normal_stencil;

  localparam int LINE_MAX = 1024;
  localparam int SETTLE_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  typedef struct packed {
    logic [15:0] nx;
    logic [14:0] ny;
    logic [15:0] nz;
    logic [9:0]  vrow;
    logic [9:0]  vcol;
  } normal_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_ready, cmd;
  logic signed [15:0] height;
  logic out_valid, out_ready;
  logic signed [15:0] normal_x, normal_z;
  logic [14:0] normal_y;
  logic [9:0] vertex_row, vertex_col;

  // Shadow copy of the stencil state
  logic signed [15:0] upper_line [LINE_MAX];
  logic signed [15:0] older_line [LINE_MAX];
  int unsigned row_pos, col_pos;
  int unsigned cfg_row_length, cfg_width_scale;

  normal_t pending_normals[$];
  int errors;
  bit quiet;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned rx_hold;
  int unsigned rx_gap;

  heightmap_normal_stencil i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .height(height),
    .out_valid(out_valid), .out_ready(out_ready),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .vertex_row(vertex_row), .vertex_col(vertex_col)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int unsigned idle_draw();
    if (quiet) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic longint unsigned isqrt_u64(input longint unsigned v);
    longint unsigned acc, bitv;
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v = v - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc;
  endfunction

  // Scale one component to Q1.14, round half away, saturate, restore sign
  function automatic logic [15:0] scale_q14(input longint v, input longint unsigned norm);
    longint unsigned mag, q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = (mag * 16384 + norm / 2) / norm;
    if (q > 16384) q = 16384;
    if (v < 0) return 16'(0 - q);
    return 16'(q);
  endfunction

  // Advance the shadow state by one accepted word and queue the normal it yields, if any
  task automatic predict_normal(input logic c_in, input logic signed [15:0] h_in);
    bit is_drain;
    int unsigned len, c, r, ns;
    longint h, p, nx, nz, ny;
    longint unsigned s, norm;
    normal_t n;
    is_drain = (c_in == CMD_DRAIN);
    h = h_in;
    len = cfg_row_length;
    if (len < 2) len = 2;
    if (len > LINE_MAX) len = LINE_MAX;
    c = col_pos;
    r = row_pos;
    if (c >= len) c = len - 1;
    if (is_drain && r == 0) return;
    if (r != 0) begin
      p = upper_line[c];
      nx = 0;
      nz = 0;
      ns = 0;
      if (!is_drain) begin nx += p - h; ns++; end
      if (r > 1) begin nx += longint'(older_line[c]) - p; ns++; end
      if (c + 1 < len) begin nz += p - longint'(upper_line[c+1]); ns++; end
      if (c > 0) begin nz += longint'(older_line[c-1]) - p; ns++; end
      ny = longint'(cfg_width_scale) * ns;
      s = nx * nx + ny * ny + nz * nz;
      norm = isqrt_u64(s);
      if (norm == 0) begin
        n.nx = '0;
        n.ny = 15'd16384;
        n.nz = '0;
      end else begin
        n.nx = scale_q14(nx, norm);
        n.ny = 15'(scale_q14(ny, norm));
        n.nz = scale_q14(nz, norm);
      end
      n.vrow = 10'(r - 1);
      n.vcol = 10'(c);
      pending_normals.push_back(n);
    end
    older_line[c] = upper_line[c];
    if (!is_drain) upper_line[c] = h_in;
    if (c + 1 >= len) begin
      col_pos = 0;
      row_pos = is_drain ? 0 : ((r + 1) & 10'h3FF);
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic check_normal();
    normal_t w;
    if (pending_normals.size() == 0) begin
      report_mismatch("unexpected word at row", vertex_row, -1);
      return;
    end
    w = pending_normals.pop_front();
    if (normal_x !== w.nx) report_mismatch("normal_x", normal_x, $signed(w.nx));
    if (normal_y !== w.ny) report_mismatch("normal_y", normal_y, w.ny);
    if (normal_z !== w.nz) report_mismatch("normal_z", normal_z, $signed(w.nz));
    if (vertex_row !== w.vrow) report_mismatch("vertex_row", vertex_row, w.vrow);
    if (vertex_col !== w.vcol) report_mismatch("vertex_col", vertex_col, w.vcol);
  endtask

  // Receive side: check each word, then stall for a drawn gap or a forced hold
  always @(posedge clk) begin
    int unsigned g;
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
      rx_hold <= 0;
      hold_seen <= hold_req;
    end else begin
      if (out_valid && out_ready) check_normal();
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        rx_hold <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        g = idle_draw();
        rx_gap <= g;
        out_ready <= (g == 0);
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ready <= (rx_gap == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic c_in, input logic signed [15:0] h_in);
    int unsigned g;
    g = idle_draw();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c_in;
    height <= h_in;
    do @(posedge clk); while (!in_ready);
    predict_normal(c_in, h_in);
  endtask

  // Wait for every queued normal, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == hns_pkg::REG_ROW_LENGTH) cfg_row_length = value & 11'h7FF;
    else cfg_width_scale = value & 16'hFFFF;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input int unsigned len, input int unsigned ws);
    write_reg(hns_pkg::REG_ROW_LENGTH, len);
    write_reg(hns_pkg::REG_WIDTH_SCALE, ws);
  endtask

  function automatic logic signed [15:0] draw_height();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'($urandom_range(0, 64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send rows full rows of samples, then one drain row
  task automatic send_frame(input int unsigned len, input int unsigned rows);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < len; c++) send_word(CMD_SAMPLE, draw_height());
    for (int c = 0; c < len; c++) send_word(CMD_DRAIN, 16'($urandom));
  endtask

  task automatic test_full_width_row();
    // Oversized length clamps to the full line width
    configure(2047, 256);
    send_word(CMD_DRAIN, 16'sh1234);
    for (int c = 0; c < 1024; c++) send_word(CMD_SAMPLE, draw_height());
    for (int c = 0; c < 4; c++) send_word(CMD_SAMPLE, draw_height());
    wait_idle();
    // Shrink the row so the next sample closes it, then drain
    write_reg(hns_pkg::REG_ROW_LENGTH, 2);
    send_word(CMD_SAMPLE, draw_height());
    send_word(CMD_DRAIN, 16'($urandom));
    send_word(CMD_DRAIN, 16'($urandom));
    wait_idle();
  endtask

  task automatic test_edge_values();
    configure(2, 1);
    send_word(CMD_SAMPLE, 16'sh7FFF);
    send_word(CMD_SAMPLE, -16'sh8000);
    send_word(CMD_SAMPLE, -16'sh8000);
    send_word(CMD_SAMPLE, 16'sh7FFF);
    send_word(CMD_SAMPLE, 16'sh0000);
    send_word(CMD_SAMPLE, 16'shFFFF);
    send_word(CMD_DRAIN, 16'sh0);
    send_word(CMD_DRAIN, 16'sh0);
    wait_idle();
    configure(1, 65535);
    send_frame(2, 3);
    wait_idle();
    // Flat map with zero spacing gives a zero norm
    write_reg(hns_pkg::REG_WIDTH_SCALE, 0);
    for (int i = 0; i < 4; i++) send_word(CMD_SAMPLE, 16'sh0100);
    send_word(CMD_DRAIN, 16'sh0);
    send_word(CMD_DRAIN, 16'sh0);
    wait_idle();
  endtask

  task automatic test_shrunken_row();
    configure(8, 300);
    for (int c = 0; c < 5; c++) send_word(CMD_SAMPLE, draw_height());
    wait_idle();
    write_reg(hns_pkg::REG_ROW_LENGTH, 3);
    send_word(CMD_SAMPLE, draw_height());
    send_frame(3, 2);
    wait_idle();
  endtask

  task automatic test_backpressure();
    configure(4, 512);
    quiet = 1;
    hold_req++;
    send_frame(4, 5);
    quiet = 0;
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned sent, len, rows, ws;
    sent = 0;
    while (sent < 860) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(2, 16);
      rows = $urandom_range(1, 8);
      case ($urandom_range(0, 5))
        0: ws = 1;
        1: ws = 65535;
        2: ws = $urandom_range(1, 1024);
        default: ws = $urandom_range(1, 65535);
      endcase
      configure(len, ws);
      quiet = ($urandom_range(0, 3) == 0);
      // Stray drains at row zero are ignored
      if ($urandom_range(0, 3) == 0) send_word(CMD_DRAIN, 16'($urandom));
      send_frame(len, rows);
      sent += len * (rows + 1);
      quiet = 0;
      wait_idle();
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    cmd = CMD_SAMPLE;
    height = '0;
    errors = 0;
    quiet = 0;
    hold_req = 0;
    row_pos = 0;
    col_pos = 0;
    cfg_row_length = hns_pkg::ROW_LENGTH_RST;
    cfg_width_scale = hns_pkg::WIDTH_SCALE_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_full_width_row();
    test_edge_values();
    test_shrunken_row();
    test_backpressure();
    test_random_frames();
    wait_idle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> heightmap_normal_stencil.f
rtl/hns_pkg.sv
rtl/hns_fifo.sv
rtl/hns_front.sv
rtl/hns_back.sv
rtl/heightmap_normal_stencil.sv
sim/tb_heightmap_normal_stencil.sv
